// ===== design/ogrc_pkg.sv =====
`default_nettype none
package ogrc_pkg;

   localparam int GRID_CELLS  = 32;
   localparam int IDX_W       = $clog2(GRID_CELLS);
   localparam int POS_W       = 16;
   localparam int AREA_W      = 15;
   localparam int CELL_W      = 12;
   localparam int QUO_W       = AREA_W;
   localparam int HIT_W       = 11;
   localparam int ACC_W       = $clog2(GRID_CELLS * GRID_CELLS + 1);
   localparam int CNT_W       = $clog2(GRID_CELLS + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_CHECK_REGION = 2'd0;
   localparam logic [1:0] OP_SET_REGION   = 2'd1;
   localparam logic [1:0] OP_CLEAR_REGION = 2'd2;
   localparam logic [1:0] OP_CHECK_CELL   = 2'd3;

   localparam logic [1:0] KIND_CHECK = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef logic [GRID_CELLS-1:0] column_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             scan;
      logic             coll_pre;
      logic [IDX_W-1:0] x_lo;
      logic [IDX_W-1:0] x_hi;
      logic [IDX_W-1:0] y_lo;
      logic [IDX_W-1:0] y_hi;
   } command_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_width;
      logic [CELL_W-1:0] cell_height;
      logic [AREA_W-1:0] area_width;
      logic [AREA_W-1:0] area_height;
   } config_type;

   function automatic column_type border_column(input int col);
      column_type w;
      w = '0;
      w[0] = 1'b1;
      w[GRID_CELLS-1] = 1'b1;
      if (col == 0 || col == GRID_CELLS - 1) begin
         w = '1;
      end
      return w;
   endfunction

   function automatic column_type range_mask(input logic [IDX_W-1:0] lo,
                                             input logic [IDX_W-1:0] hi);
      column_type m;
      for (int b = 0; b < GRID_CELLS; b++) begin
         m[b] = (IDX_W'(b) >= lo) && (IDX_W'(b) <= hi);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== design/occupancy_grid_region_check.sv =====
// check_cell skips the dividers; region operations first run four 15-step
// cell-size dividers, then scan one grid column a cycle (up to 32), the last
// only once the response slot is free. The front takes no new transaction
// until the last is in the 2-entry queue; the back pops a command only when idle.
// Reset (synchronous): border cells set, interior clear, registers at defaults.
`default_nettype none
module occupancy_grid_region_check
   import ogrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // x_start, x_end, y_start, y_end
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // collision, hit_count, zero pad
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
   localparam logic [1:0] REG_AREA_WIDTH  = 2'd2;
   localparam logic [1:0] REG_AREA_HEIGHT = 2'd3;

   config_type       cfg_ff, cfg_in;
   logic             cfg_write;
   logic [1:0]       reg_index;
   logic             push;
   logic             queue_full;
   logic             queue_valid;
   logic             pop;
   command_type      push_cmd;
   command_type      head_cmd;
   logic             collision;
   logic [HIT_W-1:0] hit_count;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_CELL_WIDTH:  cfg_in.cell_width  = csr_pwdata[CELL_W-1:0];
            REG_CELL_HEIGHT: cfg_in.cell_height = csr_pwdata[CELL_W-1:0];
            REG_AREA_WIDTH:  cfg_in.area_width  = csr_pwdata[AREA_W-1:0];
            REG_AREA_HEIGHT: cfg_in.area_height = csr_pwdata[AREA_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CELL_WIDTH:  csr_prdata = 32'(cfg_ff.cell_width);
         REG_CELL_HEIGHT: csr_prdata = 32'(cfg_ff.cell_height);
         REG_AREA_WIDTH:  csr_prdata = 32'(cfg_ff.area_width);
         REG_AREA_HEIGHT: csr_prdata = 32'(cfg_ff.area_height);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_width  <= CELL_W'(16);
         cfg_ff.cell_height <= CELL_W'(16);
         cfg_ff.area_width  <= AREA_W'(512);
         cfg_ff.area_height <= AREA_W'(512);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ogrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_x_start (req_tdata[15:0]),
      .req_x_end   (req_tdata[31:16]),
      .req_y_start (req_tdata[47:32]),
      .req_y_end   (req_tdata[63:48]),
      .queue_full  (queue_full),
      .push        (push),
      .cmd         (push_cmd)
   );

   ogrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_data  (head_cmd)
   );

   ogrc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (queue_valid),
      .cmd           (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_collision (collision),
      .rsp_hit_count (hit_count)
   );

   assign rsp_tdata = {(16 - HIT_W - 1)'(0), hit_count, collision};

endmodule
`default_nettype wire

// ===== design/ogrc_div.sv =====
`default_nettype none
module ogrc_div
   import ogrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic              run,
   input  wire logic [QUO_W-1:0]  dividend,
   input  wire logic [CELL_W-1:0] divisor,
   output logic      [QUO_W-1:0]  quotient
);

   logic [CELL_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CELL_W-1:0] dsr_ff, dsr_in;
   logic [CELL_W:0]   shifted;

   always_comb begin
      shifted = {rem_ff[CELL_W-1:0], quo_ff[QUO_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         // a zero cell size behaves as one
         dsr_in = (divisor == '0) ? CELL_W'(1) : divisor;
      end else if (run) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/ogrc_front.sv =====
`default_nettype none
module ogrc_front
   import ogrc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire config_type       cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_op,
   input  wire logic [POS_W-1:0] req_x_start,
   input  wire logic [POS_W-1:0] req_x_end,
   input  wire logic [POS_W-1:0] req_y_start,
   input  wire logic [POS_W-1:0] req_y_end,
   input  wire logic             queue_full,
   output logic                  push,
   output command_type           cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;
   localparam int STEP_W = $clog2(QUO_W);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        op_ff, op_in;
   logic [POS_W-1:0]  pos_ff [4];
   logic [POS_W-1:0]  pos_in [4];
   logic [3:0]        valid_ff, valid_in;
   logic [QUO_W-1:0]  quo [4];
   logic              accept;
   logic              run;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign run       = (state_ff == S_DIV);

   always_comb begin
      pos_in[0] = req_x_start;
      pos_in[1] = req_x_end;
      pos_in[2] = req_y_start;
      pos_in[3] = req_y_end;
      for (int k = 0; k < 4; k++) begin
         valid_in[k] = !pos_in[k][POS_W-1] &&
                       (pos_in[k][AREA_W-1:0] < ((k < 2) ? cfg.area_width : cfg.area_height));
      end
   end

   ogrc_div u_div_xs (.clock(clock), .load(accept), .run(run), .dividend(req_x_start[QUO_W-1:0]),
                      .divisor(cfg.cell_width), .quotient(quo[0]));
   ogrc_div u_div_xe (.clock(clock), .load(accept), .run(run), .dividend(req_x_end[QUO_W-1:0]),
                      .divisor(cfg.cell_width), .quotient(quo[1]));
   ogrc_div u_div_ys (.clock(clock), .load(accept), .run(run), .dividend(req_y_start[QUO_W-1:0]),
                      .divisor(cfg.cell_height), .quotient(quo[2]));
   ogrc_div u_div_ye (.clock(clock), .load(accept), .run(run), .dividend(req_y_end[QUO_W-1:0]),
                      .divisor(cfg.cell_height), .quotient(quo[3]));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      op_in    = op_ff;
      push     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               step_in  = '0;
               state_in = (req_op == OP_CHECK_CELL) ? S_PUSH : S_DIV;
            end
         end
         S_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      op_ff   <= op_in;
      if (accept) begin
         for (int k = 0; k < 4; k++) begin
            pos_ff[k] <= pos_in[k];
         end
         valid_ff <= valid_in;
      end
   end

   // turn cell indices into a scan command
   always_comb begin
      logic [3:0]       on_grid;
      logic [QUO_W-1:0] clamp [4];
      logic [QUO_W-1:0] lx, ly;
      logic             cx_in, cy_in;
      for (int k = 0; k < 4; k++) begin
         on_grid[k] = quo[k] < QUO_W'(GRID_CELLS);
         clamp[k]   = on_grid[k] ? quo[k] : QUO_W'(GRID_CELLS - 1);
      end
      lx    = valid_ff[0] ? quo[0] : '0;
      ly    = valid_ff[2] ? quo[2] : '0;
      cx_in = !pos_ff[0][POS_W-1] && (pos_ff[0][QUO_W-1:0] < QUO_W'(GRID_CELLS));
      cy_in = !pos_ff[2][POS_W-1] && (pos_ff[2][QUO_W-1:0] < QUO_W'(GRID_CELLS));

      cmd.kind     = KIND_CHECK;
      cmd.scan     = 1'b0;
      cmd.coll_pre = 1'b0;
      cmd.x_lo     = quo[0][IDX_W-1:0];
      cmd.x_hi     = clamp[1][IDX_W-1:0];
      cmd.y_lo     = quo[2][IDX_W-1:0];
      cmd.y_hi     = clamp[3][IDX_W-1:0];
      case (op_ff)
         OP_CHECK_REGION: begin
            if (valid_ff != 4'b1111) begin
               cmd.coll_pre = 1'b1;
            end else if (quo[0] <= quo[1] && quo[2] <= quo[3]) begin
               cmd.coll_pre = !on_grid[1] || !on_grid[3];
               cmd.scan     = on_grid[0] && on_grid[2];
            end
         end
         OP_SET_REGION, OP_CLEAR_REGION: begin
            cmd.kind = (op_ff == OP_SET_REGION) ? KIND_SET : KIND_CLEAR;
            cmd.x_lo = lx[IDX_W-1:0];
            cmd.y_lo = ly[IDX_W-1:0];
            cmd.scan = valid_ff[1] && valid_ff[3] && (lx <= clamp[1]) && (ly <= clamp[3]);
         end
         OP_CHECK_CELL: begin
            cmd.x_lo     = pos_ff[0][IDX_W-1:0];
            cmd.x_hi     = pos_ff[0][IDX_W-1:0];
            cmd.y_lo     = pos_ff[2][IDX_W-1:0];
            cmd.y_hi     = pos_ff[2][IDX_W-1:0];
            cmd.scan     = cx_in && cy_in;
            cmd.coll_pre = !(cx_in && cy_in) && ((&pos_ff[0]) || (&pos_ff[2]));
         end
         default: begin
            cmd.scan = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/ogrc_fifo.sv =====
`default_nettype none
module ogrc_fifo
   import ogrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire command_type push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             not_empty,
   output command_type      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   command_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/ogrc_back.sv =====
`default_nettype none
module ogrc_back
   import ogrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire command_type cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_collision,
   output logic [HIT_W-1:0] rsp_hit_count
);

   localparam int SAT_W = (ACC_W > HIT_W) ? ACC_W : HIT_W;

   column_type        grid_ff [GRID_CELLS];
   column_type        grid_in [GRID_CELLS];
   logic              busy_ff, busy_in;
   command_type       cur_ff, cur_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              valid_ff, valid_in;
   logic              coll_ff, coll_in;
   logic [HIT_W-1:0]  hit_ff, hit_in;
   logic              out_free;
   logic              last;
   column_type        rd_col;
   column_type        mask;
   logic [CNT_W-1:0]  ones;
   logic [ACC_W-1:0]  acc_next;
   logic [SAT_W-1:0]  acc_wide;

   assign out_free = !valid_ff || rsp_ready;
   assign rd_col   = grid_ff[col_ff];
   assign mask     = range_mask(cur_ff.y_lo, cur_ff.y_hi);
   assign ones     = CNT_W'($countones(rd_col & mask));
   assign acc_next = acc_ff + ACC_W'(ones);
   assign acc_wide = SAT_W'(acc_next);
   assign last     = (col_ff == cur_ff.x_hi);
   assign pop      = !busy_ff && cmd_valid && (cmd.scan || out_free);

   always_comb begin
      grid_in  = grid_ff;
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      col_in   = col_ff;
      acc_in   = acc_ff;
      valid_in = valid_ff && !rsp_ready;
      coll_in  = coll_ff;
      hit_in   = hit_ff;
      if (pop) begin
         if (cmd.scan) begin
            busy_in = 1'b1;
            cur_in  = cmd;
            col_in  = cmd.x_lo;
            acc_in  = '0;
         end else begin
            valid_in = 1'b1;
            coll_in  = cmd.coll_pre;
            hit_in   = '0;
         end
      end else if (busy_ff && (!last || out_free)) begin
         case (cur_ff.kind)
            KIND_SET:   grid_in[col_ff] = rd_col | mask;
            KIND_CLEAR: grid_in[col_ff] = rd_col & ~mask;
            default:    grid_in[col_ff] = rd_col;
         endcase
         if (!last) begin
            col_in = col_ff + IDX_W'(1);
            acc_in = acc_next;
         end else begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
            if (cur_ff.kind == KIND_CHECK) begin
               coll_in = cur_ff.coll_pre || (acc_next != '0);
               hit_in  = (acc_wide > SAT_W'((1 << HIT_W) - 1)) ? '1 : acc_wide[HIT_W-1:0];
            end else begin
               coll_in = 1'b0;
               hit_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         for (int i = 0; i < GRID_CELLS; i++) begin
            grid_ff[i] <= border_column(i);
         end
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         grid_ff  <= grid_in;
      end
      cur_ff  <= cur_in;
      col_ff  <= col_in;
      acc_ff  <= acc_in;
      coll_ff <= coll_in;
      hit_ff  <= hit_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_collision = coll_ff;
   assign rsp_hit_count = hit_ff;

endmodule
`default_nettype wire
